>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the response line parser.
// No dependencies; synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define AP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AP_ASSERT(name, clk, rstn, prop, msg)
`define AP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

>>> rtl/atrlp_pkg.sv
// Package for the response line parser: request codes, line kinds,
// character constants and the code tables. No dependencies.
package atrlp_pkg;

  localparam int unsigned LINE_BYTES_DEF = 16;
  // Only the first nine bytes of a line are ever looked at.
  localparam int unsigned DEC_BYTES = 9;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_IDLE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] KIND_IGNORED = 3'd0;
  localparam logic [2:0] KIND_BAUD    = 3'd1;
  localparam logic [2:0] KIND_MODE    = 3'd2;
  localparam logic [2:0] KIND_REPORT  = 3'd3;
  localparam logic [2:0] KIND_POWER   = 3'd4;
  localparam logic [2:0] KIND_CHANNEL = 3'd5;

  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_8    = 8'h38;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [3:0] CODE_UNKNOWN = 4'd8;

  // Two-character texts, first character in the high byte.
  localparam logic [15:0] BAUD_TEXTS [8] = '{
    16'h3132, 16'h3234, 16'h3438, 16'h3936,
    16'h3139, 16'h3338, 16'h3537, 16'h3131
  };
  localparam logic [15:0] POWER_TEXTS [8] = '{
    16'h3031, 16'h3032, 16'h3035, 16'h3038,
    16'h3131, 16'h3134, 16'h3137, 16'h3230
  };

  function automatic logic [3:0] baud_code_f(input logic [15:0] text);
    logic [3:0] code;
    code = CODE_UNKNOWN;
    for (int k = 7; k >= 0; k--) begin
      if (text == BAUD_TEXTS[k]) code = 4'(k);
    end
    return code;
  endfunction

  function automatic logic [3:0] power_code_f(input logic [15:0] text);
    logic [3:0] code;
    code = CODE_UNKNOWN;
    for (int k = 7; k >= 0; k--) begin
      if (text == POWER_TEXTS[k]) code = 4'(k);
    end
    return code;
  endfunction

  function automatic logic is_digit_f(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // Value of the leading decimal digits of the three-character text.
  function automatic logic [9:0] channel_value_f(input logic [23:0] text);
    logic [9:0] a;
    logic [9:0] b;
    logic [9:0] c;
    logic       d0;
    logic       d1;
    logic       d2;
    logic [9:0] v;
    a  = {6'd0, text[19:16]};
    b  = {6'd0, text[11:8]};
    c  = {6'd0, text[3:0]};
    d0 = is_digit_f(text[23:16]);
    d1 = d0 && is_digit_f(text[15:8]);
    d2 = d1 && is_digit_f(text[7:0]);
    if (d2) begin
      v = a * 10'd100 + b * 10'd10 + c;
    end else if (d1) begin
      v = a * 10'd10 + b;
    end else if (d0) begin
      v = a;
    end else begin
      v = 10'd0;
    end
    return v;
  endfunction

endpackage

>>> rtl/at_response_line_parser_top.sv
// Response line parser for a serial radio module: one request per received
// byte or command, at most one result per carriage return. The request stream
// is taken at one request per clock; a result appears in the output register
// the cycle after the carriage return that ends a line is accepted, and
// s_axis_tready falls only while a result sits in that register untaken.
// Uses atrlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module at_response_line_parser_top #(
  parameter int unsigned LINE_BYTES = atrlp_pkg::LINE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] baud_code, [11:4] mode_char, [21:12] channel_number,
  // [25:22] power_code, [33:26] lines_decoded, [39:34] zero
  output logic [39:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser    // [2:0] line_kind
);
  import atrlp_pkg::*;

  localparam int unsigned WI_W = $clog2(LINE_BYTES + 1);

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_CAPTURE,
    RD_DONE
  } rd_state_e;

  rd_state_e       st_q, st_d;
  logic [WI_W-1:0] wi_q, wi_d;
  logic [7:0]      store_q [DEC_BYTES];
  logic [7:0]      store_d [DEC_BYTES];
  logic [7:0]      view    [DEC_BYTES];
  logic [15:0]     baud_q, baud_d;
  logic [7:0]      mode_q, mode_d;
  logic [23:0]     chan_q, chan_d;
  logic [15:0]     pwr_q, pwr_d;
  logic [7:0]      lc_q, lc_d;

  logic            out_valid_q;
  logic [33:0]     out_data_q;
  logic [2:0]      out_kind_q;

  logic            s_fire;
  logic            cr_fire;
  logic            idle_fire;
  logic            start;
  logic            cap_eff;
  logic            is_cr;
  logic [WI_W-1:0] wi_eff;
  logic [WI_W-1:0] wi_inc;
  logic            emit;
  logic [2:0]      kind;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cr_fire       = s_fire && (s_axis_tuser == OP_BYTE) && (s_axis_tdata == CH_CR);
  assign idle_fire     = s_fire && (s_axis_tuser == OP_IDLE);

  assign start   = (s_axis_tdata == CH_O) && (st_q != RD_CAPTURE);
  assign cap_eff = (st_q == RD_CAPTURE) || start;
  assign is_cr   = (s_axis_tdata == CH_CR) && (st_q == RD_CAPTURE);
  assign wi_eff  = start ? '0 : wi_q;
  assign wi_inc  = wi_q + WI_W'(1);

  always_comb begin
    st_d     = st_q;
    wi_d     = wi_q;
    store_d  = store_q;
    view     = store_q;
    baud_d   = baud_q;
    mode_d   = mode_q;
    chan_d   = chan_q;
    pwr_d    = pwr_q;
    lc_d     = lc_q;
    emit     = 1'b0;
    kind     = KIND_IGNORED;
    if (s_fire) begin
      case (s_axis_tuser)
        OP_BYTE: begin
          if (is_cr) begin
            st_d = RD_DONE;
            // The line is only decoded when the CR and its terminator fit.
            if (wi_q < WI_W'(LINE_BYTES - 1)) begin
              for (int i = 0; i < DEC_BYTES; i++) begin
                if (wi_q == WI_W'(i)) begin
                  view[i] = CH_CR;
                end else if (wi_inc == WI_W'(i)) begin
                  view[i] = 8'd0;
                end
              end
              store_d = view;
              wi_d    = wi_inc;
              emit    = 1'b1;
              lc_d    = lc_q + 8'd1;
              if ((view[2] != 8'd0) && (view[0] != CH_E)) begin
                case (view[3])
                  CH_B: begin
                    baud_d = {view[4], view[5]};
                    kind   = KIND_BAUD;
                  end
                  CH_F: begin
                    mode_d = view[5];
                    kind   = KIND_MODE;
                  end
                  CH_R: begin
                    if (view[4] == CH_C) chan_d = {view[5], view[6], view[7]};
                    if (view[4] == CH_P) pwr_d = {view[7], view[8]};
                    kind = KIND_REPORT;
                  end
                  CH_P: begin
                    if ((view[4] >= CH_1) && (view[4] <= CH_8)) begin
                      pwr_d = POWER_TEXTS[3'(view[4] - CH_1)];
                    end else begin
                      pwr_d = 16'd0;
                    end
                    kind = KIND_POWER;
                  end
                  CH_C: begin
                    chan_d = {view[4], view[5], view[6]};
                    kind   = KIND_CHANNEL;
                  end
                  default: kind = KIND_IGNORED;
                endcase
              end
            end
          end else if (cap_eff) begin
            st_d = RD_CAPTURE;
            wi_d = wi_eff;
            // Bytes past the end of the store are dropped until CR.
            if (wi_eff < WI_W'(LINE_BYTES)) begin
              for (int i = 0; i < DEC_BYTES; i++) begin
                if (wi_eff == WI_W'(i)) store_d[i] = s_axis_tdata;
              end
              wi_d = wi_eff + WI_W'(1);
            end
          end
        end
        OP_IDLE:  st_d = RD_IDLE;
        OP_CLEAR: lc_d = 8'd0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= RD_IDLE;
      wi_q        <= '0;
      for (int i = 0; i < DEC_BYTES; i++) store_q[i] <= 8'd0;
      baud_q      <= 16'd0;
      mode_q      <= 8'd0;
      chan_q      <= 24'd0;
      pwr_q       <= 16'd0;
      lc_q        <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      wi_q    <= wi_d;
      store_q <= store_d;
      baud_q  <= baud_d;
      mode_q  <= mode_d;
      chan_q  <= chan_d;
      pwr_q   <= pwr_d;
      lc_q    <= lc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {lc_d, power_code_f(pwr_d), channel_value_f(chan_d), mode_d,
                     baud_code_f(baud_d)};
      out_kind_q <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};
  assign m_axis_tuser  = out_kind_q;

  `AP_ASSERT(a_result_after_cr, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cr_fire), "no CR")
  `AP_ASSERT(a_index_in_range, clk_i, rst_ni, wi_q <= WI_W'(LINE_BYTES), "index past store")
  `AP_ASSERT(a_idle_request, clk_i, rst_ni, idle_fire |=> (st_q == RD_IDLE), "reader not idle")
  `AP_ASSERT(a_count_step, clk_i, rst_ni, emit |=> (lc_q == $past(lc_q) + 8'd1), "count stuck")

endmodule

>>> dv/tb_at_response_line_parser_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for at_response_line_parser_top: it sends received bytes and
// reader commands, predicts each decoded line and checks every reply. Uses atrlp_pkg.
module tb_at_response_line_parser_top;
  import atrlp_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int unsigned NUM_REQS   = 750;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  // Code tables as text, first character in the top byte.
  localparam logic [127:0] BAUD_LIST  = "1224489619385711";
  localparam logic [127:0] POWER_LIST = "0102050811141720";

  typedef struct packed {
    logic [3:0] baud;
    logic [7:0] mode;
    logic [9:0] channel;
    logic [3:0] power;
    logic [7:0] count;
    logic [2:0] kind;
  } line_reply_t;

  class line_reply_scoreboard;
    typedef enum logic [1:0] {RX_IDLE, RX_CAPTURE, RX_ENDED} rx_state_e;

    logic [7:0]  line_mem [LINE_BYTES_DEF];
    int unsigned wr_idx;
    rx_state_e   rx_state;
    logic [15:0] baud_text;
    logic [7:0]  mode_text;
    logic [23:0] channel_text;
    logic [15:0] power_text;
    logic [7:0]  line_count;
    line_reply_t expected_replies [$];
    int unsigned errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      wr_idx       = 0;
      rx_state     = RX_IDLE;
      baud_text    = '0;
      mode_text    = '0;
      channel_text = '0;
      power_text   = '0;
      line_count   = '0;
      errors       = 0;
    endfunction

    function logic [3:0] text_code(logic [15:0] text, logic [127:0] list);
      for (int k = 0; k < 8; k++) begin
        if (list[127 - 16 * k -: 16] == text) return 4'(k);
      end
      return CODE_UNKNOWN;
    endfunction

    function logic [9:0] channel_of(logic [23:0] text);
      logic [9:0] v;
      logic [7:0] c;
      v = '0;
      for (int s = 2; s >= 0; s--) begin
        c = text[8 * s +: 8];
        if (c < CH_0 || c > CH_9) break;
        v = v * 10'd10 + 10'(c - CH_0);
      end
      return v;
    endfunction

    // Fixed-position decode of the line store; the count moves even for ignored lines.
    function logic [2:0] decode_line();
      logic [2:0] kind;
      logic [7:0] d;
      kind = KIND_IGNORED;
      line_count = line_count + 8'd1;
      if (line_mem[2] == 8'h00 || line_mem[0] == CH_E) return KIND_IGNORED;
      case (line_mem[3])
        CH_B: begin
          baud_text = {line_mem[4], line_mem[5]};
          kind = KIND_BAUD;
        end
        CH_F: begin
          mode_text = line_mem[5];
          kind = KIND_MODE;
        end
        CH_R: begin
          if (line_mem[4] == CH_C) channel_text = {line_mem[5], line_mem[6], line_mem[7]};
          if (line_mem[4] == CH_P) power_text = {line_mem[7], line_mem[8]};
          kind = KIND_REPORT;
        end
        CH_P: begin
          d = line_mem[4];
          if (d >= CH_1 && d <= CH_8) begin
            power_text = POWER_LIST[127 - 16 * int'(d - CH_1) -: 16];
          end else begin
            power_text = '0;
          end
          kind = KIND_POWER;
        end
        CH_C: begin
          channel_text = {line_mem[4], line_mem[5], line_mem[6]};
          kind = KIND_CHANNEL;
        end
        default: ;
      endcase
      return kind;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] b);
      line_reply_t r;
      logic        emit;
      emit = 1'b0;
      r    = '0;
      case (op)
        OP_IDLE:  rx_state = RX_IDLE;
        OP_CLEAR: line_count = '0;
        OP_BYTE: begin
          if (b == CH_O && rx_state != RX_CAPTURE) begin
            rx_state = RX_CAPTURE;
            wr_idx   = 0;
          end
          if (b == CH_CR && rx_state == RX_CAPTURE) begin
            rx_state = RX_ENDED;
            // The CR and a terminating zero both need room, else the line is lost.
            if (wr_idx + 1 < LINE_BYTES_DEF) begin
              line_mem[wr_idx] = b;
              wr_idx++;
              line_mem[wr_idx] = 8'h00;
              r.kind = decode_line();
              emit   = 1'b1;
            end
          end
          if (rx_state == RX_CAPTURE && wr_idx < LINE_BYTES_DEF) begin
            line_mem[wr_idx] = b;
            wr_idx++;
          end
        end
        default: ;
      endcase
      if (emit) begin
        r.baud    = text_code(baud_text, BAUD_LIST);
        r.mode    = mode_text;
        r.channel = channel_of(channel_text);
        r.power   = text_code(power_text, POWER_LIST);
        r.count   = line_count;
        expected_replies.push_back(r);
      end
    endfunction

    function void flag_error(string what, line_reply_t exp_r, line_reply_t act_r);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s: expected baud %0d mode %02h channel %0d power %0d count %0d kind %0d",
                 $realtime, what, exp_r.baud, exp_r.mode, exp_r.channel, exp_r.power,
                 exp_r.count, exp_r.kind);
        $display("%0t: %s:   actual baud %0d mode %02h channel %0d power %0d count %0d kind %0d",
                 $realtime, what, act_r.baud, act_r.mode, act_r.channel, act_r.power,
                 act_r.count, act_r.kind);
      end
    endfunction

    function void check_reply(logic [39:0] data, logic [2:0] kind);
      line_reply_t act_r;
      line_reply_t exp_r;
      act_r = {data[3:0], data[11:4], data[21:12], data[25:22], data[33:26], kind};
      if (expected_replies.size() == 0) begin
        flag_error("reply with none pending", '0, act_r);
      end else begin
        exp_r = expected_replies.pop_front();
        if (act_r.baud != exp_r.baud || act_r.mode != exp_r.mode ||
            act_r.channel != exp_r.channel || act_r.power != exp_r.power ||
            act_r.count != exp_r.count || act_r.kind != exp_r.kind ||
            data[39:34] != 6'd0) begin
          flag_error("reply mismatch", exp_r, act_r);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic [1:0]  s_axis_tuser  = OP_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  line_reply_scoreboard sb = new();
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles  = 0;
  bit          steady        = 1'b0;

  always #4 clk_i = ~clk_i;

  at_response_line_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 27);
  end

  // Both handshakes are sampled here, with the values they held before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
    steady = (requests_sent >= 300 && requests_sent < 420);
  endtask

  task automatic send_line(input string text);
    for (int i = 0; i < text.len(); i++) send_req(OP_BYTE, text[i]);
    send_req(OP_BYTE, CH_CR);
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return CH_0 + 8'($urandom_range(9));
  endfunction

  // Mostly well-formed replies with random content; some are cut short or never ended.
  task automatic send_random_line();
    logic [7:0]  text_bytes [18];
    logic [15:0] pair;
    int unsigned len;
    int unsigned r;
    text_bytes[0] = CH_O;
    text_bytes[1] = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CH_K;
    r = $urandom_range(9);
    text_bytes[2] = (r == 0) ? 8'h00 : (r == 1) ? 8'($urandom_range(255)) : CH_PLUS;
    case ($urandom_range(6))
      0:       text_bytes[3] = CH_B;
      1:       text_bytes[3] = CH_F;
      2:       text_bytes[3] = CH_R;
      3:       text_bytes[3] = CH_P;
      4:       text_bytes[3] = CH_C;
      default: text_bytes[3] = 8'($urandom_range(255));
    endcase
    for (int k = 4; k < 18; k++) text_bytes[k] = text_char();
    case (text_bytes[3])
      CH_B: begin
        if ($urandom_range(1) == 0) begin
          pair = BAUD_LIST[127 - 16 * $urandom_range(7) -: 16];
          text_bytes[4] = pair[15:8];
          text_bytes[5] = pair[7:0];
        end
      end
      CH_R: begin
        r = $urandom_range(4);
        text_bytes[4] = (r < 2) ? CH_C : (r < 4) ? CH_P : 8'($urandom_range(255));
        if (text_bytes[4] == CH_P && $urandom_range(1) == 0) begin
          pair = POWER_LIST[127 - 16 * $urandom_range(7) -: 16];
          text_bytes[7] = pair[15:8];
          text_bytes[8] = pair[7:0];
        end
      end
      default: ;
    endcase
    r = $urandom_range(99);
    if (r < 5) len = $urandom_range(3, 1);
    else if (r < 90) len = $urandom_range(10, 4);
    else len = $urandom_range(18, 11);
    for (int k = 0; k < len; k++) send_req(OP_BYTE, text_bytes[k]);
    if ($urandom_range(19) != 0) send_req(OP_BYTE, CH_CR);
    else if ($urandom_range(1) == 0) send_req(OP_IDLE, 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    case ($urandom_range(9))
      0, 1, 2, 3: send_req(OP_BYTE, 8'($urandom_range(255)));
      4, 5:       send_req(OP_IDLE, 8'($urandom_range(255)));
      6:          send_req(OP_CLEAR, 8'($urandom_range(255)));
      7:          send_req(OP_NONE, 8'($urandom_range(255)));
      default:    send_req(OP_BYTE, CH_CR);
    endcase
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short line decoded while every saved text still holds its reset value.
    send_line("OK");
    send_req(OP_CLEAR, 8'hFF);
    send_req(OP_NONE, 8'h00);
    // Set-power digit outside 1..8 clears the saved power text.
    send_line("OK+P9");
    // Over-long line: the store fills, later bytes drop and the CR finds no room.
    send_req(OP_BYTE, CH_O);
    for (int k = 0; k < 17; k++) begin
      send_req(OP_BYTE, (k == 3) ? 8'h00 : (k == 7) ? 8'hFF : 8'h41 + 8'(k));
    end
    send_req(OP_BYTE, CH_CR);
    send_req(OP_IDLE, 8'hA5);

    while (requests_sent < NUM_REQS) begin
      if ($urandom_range(99) < 85) send_random_line();
      else send_noise();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
